/* hw/rtl/adc_link_bringup_and_sampler_assert.svh */
`ifndef ADC_LINK_BRINGUP_AND_SAMPLER_ASSERT_SVH
`define ADC_LINK_BRINGUP_AND_SAMPLER_ASSERT_SVH

// same-cycle implication, sampled on the rising edge, off during reset
`define ALS_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication
`define ALS_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

/* hw/rtl/als_pkg.sv */
package als_pkg;

   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 4'd1;

   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   localparam logic [11:0] ST_READY_HI = 12'hff0;
   localparam logic [15:0] ST_UNLOCK   = 16'h0655;
   localparam logic [7:0]  ST_WREG_HI  = 8'h4b;
   localparam logic [15:0] ST_WAKEUP   = 16'h0033;
   localparam logic [15:0] ST_LOCK     = 16'h0555;

   localparam logic [4:0] BYTES_CMD   = 5'd4;
   localparam logic [4:0] BYTES_WREG  = 5'd24;
   localparam logic [4:0] BYTES_READ2 = 5'd12;
   localparam logic [4:0] BYTES_READ4 = 5'd20;

   localparam logic [3:0] WIDE_CHANNELS = 4'd2;

   typedef enum logic [2:0] {
      PH_STARTUP = 3'd0,
      PH_UNLOCK  = 3'd1,
      PH_CONFIG  = 3'd2,
      PH_WAKEUP  = 3'd3,
      PH_LOCK    = 3'd4,
      PH_RUN     = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      K_NULL   = 3'd0,
      K_UNLOCK = 3'd1,
      K_WREG   = 3'd2,
      K_WAKEUP = 3'd3,
      K_LOCK   = 3'd4,
      K_READ   = 3'd5
   } cmd_type;

   typedef struct packed {
      logic        block_enable;
      logic [15:0] timeout_us;
   } cfg_type;

   typedef struct packed {
      logic        xfer_done;
      logic [15:0] status_word;
      logic [23:0] raw_ch0;
      logic [23:0] raw_ch1;
      logic [23:0] raw_ch2;
      logic [23:0] raw_ch3;
      logic        ready_pin_n;
      logic [15:0] elapsed_us;
      logic        sink_full;
   } req_type;

   typedef struct packed {
      logic               send_command;
      logic [2:0]         command_kind;
      logic [4:0]         transfer_bytes;
      logic               sample_valid;
      logic               sample_lost;
      logic signed [23:0] sample0;
      logic signed [23:0] sample1;
      logic signed [23:0] sample2;
      logic signed [23:0] sample3;
      logic [2:0]         phase_now;
      logic [31:0]        samples_taken;
      logic [31:0]        samples_dropped;
   } rsp_type;

   function automatic cmd_type cmd_of(input phase_type ph);
      cmd_type k;
      unique case (ph)
         PH_UNLOCK: k = K_UNLOCK;
         PH_CONFIG: k = K_WREG;
         PH_WAKEUP: k = K_WAKEUP;
         PH_LOCK:   k = K_LOCK;
         PH_RUN:    k = K_READ;
         default:   k = K_NULL;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] bytes_of(input phase_type ph, input logic wide);
      logic [4:0] b;
      unique case (ph)
         PH_CONFIG: b = BYTES_WREG;
         PH_RUN:    b = wide ? BYTES_READ4 : BYTES_READ2;
         default:   b = BYTES_CMD;
      endcase
      return b;
   endfunction

endpackage

/* hw/rtl/adc_link_bringup_and_sampler.sv */
// A req beat goes into the input reg; its rsp beat is then offered from the result reg.
// Throughput: one poll per cycle unless rsp stalls; the decode fits between the two registers.
// A valid rsp beat holds in the result register while rsp_stall is high; req_stall
// rises only when both registers are full and the result is stalled.
// Reset (synchronous, active high): phase startup, channel count, idle timer and
// counters cleared, block disabled, timeout 1000 us.
module adc_link_bringup_and_sampler (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  als_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output als_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [als_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [als_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   als_pkg::cfg_type cfg;
   als_pkg::req_type item_ff;
   als_pkg::rsp_type result;
   als_pkg::rsp_type rsp_ff;
   logic             in_valid_ff, in_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_open;
   logic             step;
   logic             load;

   als_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   als_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .cfg    (cfg),
      .item   (item_ff),
      .result (result)
   );

   assign out_open     = !rsp_valid_ff || !rsp_stall;
   assign step         = in_valid_ff && out_open;
   assign req_stall    = in_valid_ff && !out_open;
   assign load         = req_valid && !req_stall;
   assign in_valid_in  = load || (in_valid_ff && !step);
   assign rsp_valid_in = step || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_data;
      end
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hw/rtl/als_csr.sv */
module als_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [als_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [als_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output als_pkg::cfg_type                cfg
);

   logic        enable_ff, enable_in;
   logic [15:0] timeout_ff, timeout_in;

   assign csr_ready = 1'b1;

   always_comb begin
      enable_in  = enable_ff;
      timeout_in = timeout_ff;
      if (csr_valid) begin
         unique case (csr_index)
            als_pkg::CSR_ENABLE:  enable_in  = csr_wdata[0];
            als_pkg::CSR_TIMEOUT: timeout_in = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         timeout_ff <= als_pkg::TIMEOUT_RESET;
      end else begin
         enable_ff  <= enable_in;
         timeout_ff <= timeout_in;
      end
   end

   assign cfg.block_enable = enable_ff;
   assign cfg.timeout_us   = timeout_ff;

endmodule

/* hw/rtl/als_core.sv */
module als_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  als_pkg::cfg_type cfg,
   input  als_pkg::req_type item,
   output als_pkg::rsp_type result
);

   als_pkg::phase_type phase_ff, phase_in;
   logic [3:0]         chan_ff, chan_in;
   logic [15:0]        idle_ff, idle_in;
   logic [31:0]        taken_ff, taken_in;
   logic [31:0]        dropped_ff, dropped_in;

   logic [16:0]        idle_sum;
   logic [15:0]        idle_sat;
   logic               wide;
   logic               issue;

   assign idle_sum = {1'b0, idle_ff} + {1'b0, item.elapsed_us};
   assign idle_sat = idle_sum[16] ? 16'hffff : idle_sum[15:0];
   assign wide     = chan_ff > als_pkg::WIDE_CHANNELS;

   always_comb begin
      phase_in   = phase_ff;
      chan_in    = chan_ff;
      idle_in    = idle_ff;
      taken_in   = taken_ff;
      dropped_in = dropped_ff;
      issue      = 1'b0;
      result     = '0;
      if (cfg.block_enable) begin
         unique case (phase_ff)
            als_pkg::PH_UNLOCK: begin
               issue = 1'b1;
               if (item.xfer_done && item.status_word == als_pkg::ST_UNLOCK) begin
                  phase_in = als_pkg::PH_CONFIG;
                  idle_in  = '0;
               end
            end
            als_pkg::PH_CONFIG: begin
               issue = 1'b1;
               if (item.xfer_done && item.status_word[15:8] == als_pkg::ST_WREG_HI) begin
                  phase_in = als_pkg::PH_WAKEUP;
                  idle_in  = '0;
               end
            end
            als_pkg::PH_WAKEUP: begin
               issue = 1'b1;
               if (item.xfer_done && item.status_word == als_pkg::ST_WAKEUP) begin
                  phase_in = als_pkg::PH_LOCK;
                  idle_in  = '0;
               end
            end
            als_pkg::PH_LOCK: begin
               issue = 1'b1;
               if (item.xfer_done && item.status_word == als_pkg::ST_LOCK) begin
                  phase_in = als_pkg::PH_RUN;
                  idle_in  = '0;
               end
            end
            als_pkg::PH_RUN: begin
               if (item.xfer_done) begin
                  if (item.sink_full) begin
                     dropped_in         = dropped_ff + 32'd1;
                     result.sample_lost = 1'b1;
                  end else begin
                     taken_in            = taken_ff + 32'd1;
                     result.sample_valid = 1'b1;
                     result.sample0      = $signed(item.raw_ch0);
                     result.sample1      = $signed(item.raw_ch1);
                     if (wide) begin
                        result.sample2 = $signed(item.raw_ch2);
                        result.sample3 = $signed(item.raw_ch3);
                     end
                  end
               end
               if (!item.ready_pin_n) begin
                  idle_in = '0;
                  issue   = 1'b1;
               end else if (idle_sat >= cfg.timeout_us) begin
                  phase_in = als_pkg::PH_UNLOCK;
                  idle_in  = '0;
                  issue    = 1'b1;
               end else begin
                  idle_in = idle_sat;
               end
            end
            default: begin
               issue = 1'b1;
               if (item.xfer_done && item.status_word[15:4] == als_pkg::ST_READY_HI) begin
                  chan_in  = item.status_word[3:0];
                  phase_in = als_pkg::PH_UNLOCK;
                  idle_in  = '0;
               end else begin
                  phase_in = als_pkg::PH_STARTUP;
               end
            end
         endcase
      end
      if (issue) begin
         result.send_command   = 1'b1;
         result.command_kind   = als_pkg::cmd_of(phase_in);
         result.transfer_bytes = als_pkg::bytes_of(phase_in, wide);
      end
      result.phase_now       = phase_in;
      result.samples_taken   = taken_in;
      result.samples_dropped = dropped_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= als_pkg::PH_STARTUP;
         chan_ff    <= '0;
         idle_ff    <= '0;
         taken_ff   <= '0;
         dropped_ff <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         chan_ff    <= chan_in;
         idle_ff    <= idle_in;
         taken_ff   <= taken_in;
         dropped_ff <= dropped_in;
      end
   end

endmodule

/* hw/rtl/als_checker.sv */
`include "adc_link_bringup_and_sampler_assert.svh"

module als_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input als_pkg::rsp_type rsp_data
);

   `ALS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data), "rsp beat changed while stalled")
   `ALS_ASSERT_NOW(a_no_cmd_zero, clock, reset, rsp_valid && !rsp_data.send_command,
      rsp_data.command_kind == als_pkg::K_NULL && rsp_data.transfer_bytes == 5'd0,
      "command fields set without a command")
   `ALS_ASSERT_NOW(a_no_sample_zero, clock, reset, rsp_valid && !rsp_data.sample_valid,
      rsp_data.sample0 == 24'sd0 && rsp_data.sample1 == 24'sd0 &&
      rsp_data.sample2 == 24'sd0 && rsp_data.sample3 == 24'sd0,
      "sample data without a sample")
   `ALS_ASSERT_NOW(a_read_in_run, clock, reset,
      rsp_valid && rsp_data.send_command && rsp_data.command_kind == als_pkg::K_READ,
      rsp_data.phase_now == als_pkg::PH_RUN && !(rsp_data.sample_valid && rsp_data.sample_lost),
      "read issued outside running")

endmodule

bind adc_link_bringup_and_sampler als_checker u_als_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
